### rtl/cpar_pkg.sv
// Shared types and constants for the cluster probe with age-based replacement.
`default_nettype none

package cpar_pkg;

    // Field widths of one probe word
    localparam int TAG_W      = 16;
    localparam int FLAGS_W    = 8;
    localparam int DEPTH_W    = 8;
    localparam int WAY_BITS   = TAG_W + FLAGS_W + DEPTH_W;
    localparam int MAX_WAYS   = 3;
    localparam int S_DATA_W   = TAG_W + MAX_WAYS * WAY_BITS;

    // Result fields
    localparam int WAY_W      = 2;
    localparam int M_DATA_W   = 16;

    // Replacement value: signed depth minus an age of up to 248
    localparam int VALUE_W    = 10;

    localparam logic [FLAGS_W-1:0] GEN_MASK   = 8'hF8;
    localparam logic [FLAGS_W-1:0] BOUND_MASK = 8'h07;

    // What one lane finds about its way
    typedef struct packed {
        logic                      empty;
        logic                      match;
        logic                      refresh;
        logic [FLAGS_W-1:0]        new_flags;
        logic signed [VALUE_W-1:0] value;
    } lane_t;

    // Merged result of one probe
    typedef struct packed {
        logic               hit;
        logic [WAY_W-1:0]   way;
        logic               update;
        logic [FLAGS_W-1:0] new_flags;
    } result_t;

endpackage

`default_nettype wire

### rtl/cluster_probe_age_replace.sv
// Top level: cluster probe with age-based replacement, one word per cycle while m_ does not stall.
//
//  Channel  Direction  Handshake             Payload
//  s_       in         s_tvalid / s_tready   probe tag and three ways (tag, flags, depth)
//  m_       out        m_tvalid / m_tready   hit in tuser; way, update, new flags in tdata
//  cfg_     in         cfg_valid / cfg_ready generation register
//
//  The lanes and the merge are combinational and sit in front of the output register.
//  A new word is taken every cycle while the output register is empty or being drained.
//  Reset (aresetn low, synchronous) empties the output register and clears generation.
//  A stall on m_ holds the result and stalls s_ in the same cycle, no word is dropped.
//  Generation writes are always accepted and apply to words taken afterwards.
`default_nettype none

module cluster_probe_age_replace #(
    parameter int WAYS = 3
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    // Fields from bit 0: probe_tag, way0_tag, way0_flags, way0_depth,
    // way1_tag, way1_flags, way1_depth, way2_tag, way2_flags, way2_depth
    input  wire logic [cpar_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,

    // Fields from bit 0: chosen_way, flags_update, new_flags, zero fill
    output      logic [cpar_pkg::M_DATA_W-1:0] m_tdata,
    // Fields from bit 0: hit
    output      logic                          m_tuser,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,

    input  wire logic [cpar_pkg::FLAGS_W-1:0]  cfg_data,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready
);
    import cpar_pkg::*;

    localparam int NWAYS = (WAYS > MAX_WAYS) ? MAX_WAYS : WAYS;

    logic [FLAGS_W-1:0] gen_reg;
    logic [FLAGS_W-1:0] gen_next;
    logic               valid_reg;
    logic               valid_next;
    result_t            res_reg;
    result_t            res_next;
    lane_t              lanes [NWAYS];
    logic               s_accept;

    // Configuration: always ready
    assign cfg_ready = 1'b1;
    assign gen_next  = (cfg_valid && cfg_ready) ? cfg_data : gen_reg;

    // One lane per way
    for (genvar g = 0; g < NWAYS; g++) begin : g_lane
        cpar_lane u_lane (
            .generation (gen_reg),
            .probe_tag  (s_tdata[0 +: TAG_W]),
            .way_tag    (s_tdata[TAG_W + g*WAY_BITS +: TAG_W]),
            .way_flags  (s_tdata[TAG_W + g*WAY_BITS + TAG_W +: FLAGS_W]),
            .way_depth  (s_tdata[TAG_W + g*WAY_BITS + TAG_W + FLAGS_W +: DEPTH_W]),
            .lane       (lanes[g])
        );
    end

    cpar_merge #(
        .WAYS (NWAYS)
    ) u_merge (
        .lanes  (lanes),
        .result (res_next)
    );

    // Take a word whenever the output register is free or draining
    assign s_tready = !valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (s_accept) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            gen_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            gen_reg   <= gen_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.hit;
    assign m_tdata  = {{(M_DATA_W - WAY_W - 1 - FLAGS_W){1'b0}},
                       res_reg.new_flags, res_reg.update, res_reg.way};

    // Chosen way always lies within the scanned ways
    a_way_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[WAY_W-1:0] < WAY_W'(NWAYS)))
        else $error("chosen way beyond configured ways");

    // A miss carries no flag write-back
    a_miss_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[M_DATA_W-1:WAY_W] == '0))
        else $error("miss result with flag update or flags");

    // An accepted word shows up as a result in the next cycle
    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted word produced no result");

endmodule

`default_nettype wire

### rtl/cpar_lane.sv
// One way lane: empty and tag checks, flag refresh and replacement value.
`default_nettype none

module cpar_lane (
    input  wire logic [cpar_pkg::FLAGS_W-1:0] generation,
    input  wire logic [cpar_pkg::TAG_W-1:0]   probe_tag,
    input  wire logic [cpar_pkg::TAG_W-1:0]   way_tag,
    input  wire logic [cpar_pkg::FLAGS_W-1:0] way_flags,
    input  wire logic [cpar_pkg::DEPTH_W-1:0] way_depth,
    output cpar_pkg::lane_t                   lane
);
    import cpar_pkg::*;

    logic [FLAGS_W-1:0] age;
    logic               refresh;

    // Age in whole generations, kept in the upper five bits
    assign age     = (generation - (way_flags & GEN_MASK)) & GEN_MASK;
    assign refresh = (way_flags & GEN_MASK) != generation;

    // Collect the per-way findings
    always_comb begin
        lane.empty     = (way_tag == '0);
        lane.match     = (way_tag == probe_tag);
        lane.refresh   = refresh;
        lane.new_flags = refresh ? (generation + (way_flags & BOUND_MASK)) : way_flags;
        lane.value     = VALUE_W'($signed(way_depth))
                         - $signed({{(VALUE_W-FLAGS_W){1'b0}}, age});
    end

endmodule

`default_nettype wire

### rtl/cpar_merge.sv
// Merge of the lane findings: first empty or matching way, else least-value victim.
`default_nettype none

module cpar_merge #(
    parameter int WAYS = 3
) (
    input  wire cpar_pkg::lane_t lanes [WAYS],
    output cpar_pkg::result_t    result
);
    import cpar_pkg::*;

    logic                      found;
    logic [WAY_W-1:0]          victim;
    logic signed [VALUE_W-1:0] best;

    // Pick the victim: first way holding the least value
    always_comb begin
        best   = lanes[0].value;
        victim = '0;
        for (int i = 1; i < WAYS; i++) begin
            if (lanes[i].value < best) begin
                best   = lanes[i].value;
                victim = WAY_W'(i);
            end
        end
    end

    // Scan ways in order; the first empty or matching one ends the scan
    always_comb begin
        found            = 1'b0;
        result.hit       = 1'b0;
        result.way       = victim;
        result.update    = 1'b0;
        result.new_flags = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!found && (lanes[i].empty || lanes[i].match)) begin
                found      = 1'b1;
                result.way = WAY_W'(i);
                if (!lanes[i].empty) begin
                    result.hit       = 1'b1;
                    result.update    = lanes[i].refresh;
                    result.new_flags = lanes[i].new_flags;
                end
            end
        end
    end

endmodule

`default_nettype wire
